### sv/window_min_max_mean_autoscale_defines.svh
// ----------------------------------------------------------------------------
// Window statistics assertion macros
// Shared concurrent assertion forms, reset-qualified, same-cycle and next-cycle.
// ----------------------------------------------------------------------------
`ifndef WINDOW_MIN_MAX_MEAN_AUTOSCALE_DEFINES_SVH
`define WINDOW_MIN_MAX_MEAN_AUTOSCALE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define WMM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wmm assertion failed");

// antecedent implies consequent in the next cycle
`define WMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wmm assertion failed");

`endif

### sv/wmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window statistics package
// Field widths, reset values and fixed constants of the window statistics block.
// ----------------------------------------------------------------------------
package wmm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SCALE_W     = 17;
    localparam int RATIO_W     = 12;
    localparam int DEPTH_DEF   = 64;
    localparam int MIX_W       = 20;    // 9*scale + target < 2^20

    localparam logic [SCALE_W-1:0]  SCALE_RESET = 17'd5120;   // 20 ms
    localparam logic [SCALE_W-1:0]  SCALE_FLOOR = 17'd4268;   // 16.67 ms
    localparam logic [SCALE_W-1:0]  SCALE_MAX   = 17'd78642;
    localparam logic [RATIO_W-1:0]  RATIO_RESET = 12'd384;    // 1.5 in Q4.8
    localparam logic [SAMPLE_W-1:0] SAMPLE_ALL1 = 16'hFFFF;

    localparam int TGT_DIVISOR = 5;
    localparam int SCL_DIVISOR = 10;

endpackage

### sv/wmm_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window statistics sample ring
// Sample memory with registered read; a fill count makes unwritten slots read 0.
// ----------------------------------------------------------------------------
module wmm_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [wmm_pkg::SAMPLE_W-1:0]  i_wr_data,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [wmm_pkg::SAMPLE_W-1:0]  o_rd_data
);
    import wmm_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic                r_rd_ok;
    logic [CW-1:0]       r_fill;

    // slots are written in order from 0, so slot < fill means written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_wr_en && (r_fill != CW'(DEPTH))) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_ok   <= (CW'(i_rd_addr) < r_fill);
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

### sv/wmm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window statistics divider
// Shared divide-by-constant unit: one registered multiply by the divisor's
// reciprocal, then a registered shift; o_done rises when the quotient is ready.
// ----------------------------------------------------------------------------
module wmm_div #(
    parameter int DW = 23,
    parameter int MW = 25,
    parameter int SW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [MW-1:0] i_recip,
    input  logic [SW-1:0] i_shift,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int PW = DW + MW;

    logic [DW-1:0] r_dvd;
    logic [MW-1:0] r_rcp;
    logic [SW-1:0] r_sh;
    logic [PW-1:0] r_prod;
    logic [DW-1:0] r_quo;
    logic          r_mul_go;
    logic          r_shf_go;
    logic          r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_go <= 1'b0;
            r_shf_go <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_mul_go <= i_start;
            r_shf_go <= r_mul_go;
            r_done   <= r_shf_go;
        end
    end

    // operands latch at start, product next cycle, shifted quotient after that
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rcp <= i_recip;
            r_sh  <= i_shift;
        end
        if (r_mul_go) begin
            r_prod <= PW'(r_dvd) * PW'(r_rcp);
        end
        if (r_shf_go) begin
            r_quo <= DW'(r_prod >> r_sh);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### sv/window_min_max_mean_autoscale.sv
`timescale 1ns / 1ps
// Usage:
//   Input channel : i_valid / o_ready carry one frame-time request (i_sample_time).
//   Output channel: o_valid / i_ready carry window min, max, mean, graph scale
//                   and the spike flag for that request.
//   Config        : i_cfg_we writes i_cfg_wdata to spike_ratio (Q4.8) at once;
//                   write only while the block is idle.
//   Sequence      : after accept, the ring scan reads one slot per cycle, then
//                   three divides by reciprocal multiply (mean, 6/5 target,
//                   smoothed scale) run in turn on the shared divider.
//   Requests      : one at a time; o_ready is high only while idle, so a new
//                   request is taken only after the last result is loaded
//                   into the output register.
//   Reset         : ring reads as all zero (fill count), write slot 0,
//                   scale 5120, spike_ratio 384. No clearing pass is needed.
//   Stall         : a finished result sits in the output register; the next
//                   request is taken meanwhile, and the block holds its new
//                   result until the receiver takes the old one.
// ----------------------------------------------------------------------------
// Sliding window min / max / mean with autoscale
// Sequencer over a sample ring and one shared divider.
// ----------------------------------------------------------------------------
`include "window_min_max_mean_autoscale_defines.svh"

module window_min_max_mean_autoscale #(
    parameter int WINDOW_DEPTH = wmm_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [wmm_pkg::SAMPLE_W-1:0] i_sample_time,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [wmm_pkg::SAMPLE_W-1:0] o_window_min,
    output logic [wmm_pkg::SAMPLE_W-1:0] o_window_max,
    output logic [wmm_pkg::SAMPLE_W-1:0] o_window_mean,
    output logic [wmm_pkg::SCALE_W-1:0]  o_graph_scale,
    output logic                         o_spike,
    input  logic                         i_cfg_we,
    input  logic [wmm_pkg::RATIO_W-1:0]  i_cfg_wdata
);
    import wmm_pkg::*;

    localparam int AW     = $clog2(WINDOW_DEPTH);
    localparam int CW     = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + CW;
    localparam int DIV_DW = (SUM_W > MIX_W) ? SUM_W : MIX_W;
    localparam int PROD_W = SAMPLE_W + RATIO_W;

    // floor(n / d) = (n * ceil(2^s / d)) >> s for n < 2^DIV_DW, s = DIV_DW + clog2(d)
    localparam int RCP_W   = DIV_DW + 2;
    localparam int SH_MEAN = DIV_DW + $clog2(WINDOW_DEPTH);
    localparam int SH_TGT  = DIV_DW + $clog2(TGT_DIVISOR);
    localparam int SH_SCL  = DIV_DW + $clog2(SCL_DIVISOR);
    localparam int SH_TOP  = (SH_MEAN > SH_SCL) ? SH_MEAN : SH_SCL;
    localparam int SH_W    = $clog2(SH_TOP + 1);
    localparam logic [RCP_W-1:0] RCP_MEAN = RCP_W'(((64'd1 << SH_MEAN) +
        64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));
    localparam logic [RCP_W-1:0] RCP_TGT  = RCP_W'(((64'd1 << SH_TGT) +
        64'(TGT_DIVISOR) - 64'd1) / 64'(TGT_DIVISOR));
    localparam logic [RCP_W-1:0] RCP_SCL  = RCP_W'(((64'd1 << SH_SCL) +
        64'(SCL_DIVISOR) - 64'd1) / 64'(SCL_DIVISOR));

    // sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SCAN      = 3'd1;
    localparam logic [2:0] S_DRAIN     = 3'd2;
    localparam logic [2:0] S_MEAN      = 3'd3;
    localparam logic [2:0] S_MEAN_WAIT = 3'd4;
    localparam logic [2:0] S_TGT_WAIT  = 3'd5;
    localparam logic [2:0] S_SCL_WAIT  = 3'd6;
    localparam logic [2:0] S_OUT       = 3'd7;

    logic [2:0]          r_state;
    logic [AW-1:0]       r_wr_slot;
    logic [AW-1:0]       r_idx;
    logic                r_acc_en;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_min;
    logic [SAMPLE_W-1:0] r_max;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_mean;
    logic [PROD_W-1:0]   r_prod;
    logic [SCALE_W-1:0]  r_scale;
    logic [RATIO_W-1:0]  r_ratio;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_min;
    logic [SAMPLE_W-1:0] r_out_max;
    logic [SAMPLE_W-1:0] r_out_mean;
    logic [SCALE_W-1:0]  r_out_scale;
    logic                r_out_spike;

    logic                w_accept;
    logic [SAMPLE_W-1:0] w_rd_data;
    logic                w_div_start;
    logic                w_div_done;
    logic [DIV_DW-1:0]   w_div_dvd;
    logic [RCP_W-1:0]    w_div_rcp;
    logic [SH_W-1:0]     w_div_sh;
    logic [DIV_DW-1:0]   w_div_q;
    logic [SCALE_W-1:0]  w_target;
    logic [DIV_DW-1:0]   w_mix;
    logic                w_out_load;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    wmm_ring #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_accept),
        .i_wr_addr (r_wr_slot),
        .i_wr_data (i_sample_time),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    wmm_div #(
        .DW (DIV_DW),
        .MW (RCP_W),
        .SW (SH_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_recip    (w_div_rcp),
        .i_shift    (w_div_sh),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // target = max(max*6/5, floor); quotient arrives while in S_TGT_WAIT
    assign w_target = (w_div_q < DIV_DW'(SCALE_FLOOR)) ? SCALE_FLOOR : w_div_q[SCALE_W-1:0];
    assign w_mix    = DIV_DW'({r_scale, 3'b000}) + DIV_DW'(r_scale) + DIV_DW'(w_target);

    // divider operand select: mean, then target, then smoothed scale
    always_comb begin
        case (r_state)
            S_MEAN: begin
                w_div_start = 1'b1;
                w_div_dvd   = DIV_DW'(r_sum);
                w_div_rcp   = RCP_MEAN;
                w_div_sh    = SH_W'(SH_MEAN);
            end
            S_MEAN_WAIT: begin
                w_div_start = w_div_done;
                w_div_dvd   = DIV_DW'({r_max, 2'b00}) + DIV_DW'({r_max, 1'b0});
                w_div_rcp   = RCP_TGT;
                w_div_sh    = SH_W'(SH_TGT);
            end
            S_TGT_WAIT: begin
                w_div_start = w_div_done;
                w_div_dvd   = w_mix;
                w_div_rcp   = RCP_SCL;
                w_div_sh    = SH_W'(SH_SCL);
            end
            default: begin
                w_div_start = 1'b0;
                w_div_dvd   = '0;
                w_div_rcp   = '0;
                w_div_sh    = '0;
            end
        endcase
    end

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_ready);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_slot   <= '0;
            r_acc_en    <= 1'b0;
            r_scale     <= SCALE_RESET;
            r_ratio     <= RATIO_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ratio <= i_cfg_wdata;
            end
            r_acc_en <= (r_state == S_SCAN);

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_wr_slot <= (r_wr_slot == AW'(WINDOW_DEPTH - 1)) ?
                                     '0 : r_wr_slot + 1'b1;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx == AW'(WINDOW_DEPTH - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_MEAN;
                end
                S_MEAN: begin
                    r_state <= S_MEAN_WAIT;
                end
                S_MEAN_WAIT: begin
                    if (w_div_done) begin
                        r_state <= S_TGT_WAIT;
                    end
                end
                S_TGT_WAIT: begin
                    if (w_div_done) begin
                        r_state <= S_SCL_WAIT;
                    end
                end
                S_SCL_WAIT: begin
                    if (w_div_done) begin
                        r_scale <= w_div_q[SCALE_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath: scan accumulators, mean, spike product, output register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_sample_time;
            r_idx    <= '0;
            r_min    <= SAMPLE_ALL1;
            r_max    <= '0;
            r_sum    <= '0;
        end else begin
            if (r_state == S_SCAN) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_acc_en) begin
                if (w_rd_data < r_min) r_min <= w_rd_data;
                if (w_rd_data > r_max) r_max <= w_rd_data;
                r_sum <= r_sum + SUM_W'(w_rd_data);
            end
        end
        if ((r_state == S_MEAN_WAIT) && w_div_done) begin
            r_mean <= w_div_q[SAMPLE_W-1:0];
        end
        r_prod <= PROD_W'(r_mean) * PROD_W'(r_ratio);
        if (w_out_load) begin
            r_out_min   <= r_min;
            r_out_max   <= r_max;
            r_out_mean  <= r_mean;
            r_out_scale <= r_scale;
            r_out_spike <= (PROD_W'({r_sample, 8'h00}) > r_prod);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_window_min  = r_out_min;
    assign o_window_max  = r_out_max;
    assign o_window_mean = r_out_mean;
    assign o_graph_scale = r_out_scale;
    assign o_spike       = r_out_spike;

    // a taken request always starts the scan at slot 0
    `WMM_ASSERT_NEXT(a_accept_scan, i_clk, i_rst_n, w_accept, (r_state == S_SCAN) && (r_idx == '0))
    // divider completions only land in the states that consume them
    `WMM_ASSERT_IMPL(a_div_done_state, i_clk, i_rst_n, w_div_done, (r_state == S_MEAN_WAIT) || (r_state == S_TGT_WAIT) || (r_state == S_SCL_WAIT))
    // a pending result is never overwritten while the receiver stalls
    `WMM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, (r_state == S_OUT) && r_out_valid && !i_ready, (r_state == S_OUT) && $stable(r_out_max))
    // the smoothed scale never leaves its range
    `WMM_ASSERT_IMPL(a_scale_range, i_clk, i_rst_n, r_state == S_OUT, r_scale <= SCALE_MAX)

endmodule
